>>> src/stt_pkg.sv
`default_nettype none
package stt_pkg;

  // Lexer mode; codes above LEX_COMMENT are never produced
  typedef enum logic [2:0] {
    LEX_IDLE    = 3'd0,
    LEX_OP      = 3'd1,
    LEX_NUM     = 3'd2,
    LEX_WORD    = 3'd3,
    LEX_COMMENT = 3'd4
  } lex_mode_t;

  // Token kinds
  localparam logic [4:0] K_UNKNOWN  = 5'd0;
  localparam logic [4:0] K_PLUS     = 5'd1;
  localparam logic [4:0] K_MINUS    = 5'd2;
  localparam logic [4:0] K_STAR     = 5'd3;
  localparam logic [4:0] K_SLASH    = 5'd4;
  localparam logic [4:0] K_PERCENT  = 5'd5;
  localparam logic [4:0] K_ASSIGN   = 5'd6;
  localparam logic [4:0] K_GT       = 5'd8;
  localparam logic [4:0] K_LT       = 5'd10;
  localparam logic [4:0] K_NOT      = 5'd12;
  localparam logic [4:0] K_LPAREN   = 5'd14;
  localparam logic [4:0] K_RPAREN   = 5'd15;
  localparam logic [4:0] K_LBRACKET = 5'd16;
  localparam logic [4:0] K_RBRACKET = 5'd17;
  localparam logic [4:0] K_LBRACE   = 5'd18;
  localparam logic [4:0] K_RBRACE   = 5'd19;
  localparam logic [4:0] K_NEWLINE  = 5'd20;
  localparam logic [4:0] K_EOF      = 5'd21;
  localparam logic [4:0] K_SEMI     = 5'd22;
  localparam logic [4:0] K_NUM      = 5'd23;
  localparam logic [4:0] K_IDENT    = 5'd24;
  localparam logic [4:0] K_KEYWORD0 = 5'd25;

  // Characters with a role of their own
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_EQ      = 8'h3D;

  // Keywords: let, if, else, for, while, print
  localparam int NUM_KW = 6;
  localparam logic [0:NUM_KW-1][0:4][7:0] KW_TEXT = '{
    '{"l", "e", "t", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"p", "r", "i", "n", "t"}
  };
  localparam logic [0:NUM_KW-1][2:0] KW_LEN = '{3'd3, 3'd2, 3'd4, 3'd3, 3'd5, 3'd5};

  // One emitted token
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // Tokens that are complete after one character
  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PERCENT;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      CH_NL:   k = K_NEWLINE;
      ";":     k = K_SEMI;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Operators that may take a trailing '='; zero when not one
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "=":     k = K_ASSIGN;
      ">":     k = K_GT;
      "<":     k = K_LT;
      "!":     k = K_NOT;
      default: k = 5'd0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> src/source_text_tokenizer_core.sv
`default_nettype none
// Streaming tokenizer: one source byte (or an end marker) per transaction, tokens out as
// kind, start offset and length. A byte is lexed in the cycle it is accepted, so the input
// takes one transaction per clock; the only limit is a four-entry token queue in front of
// the result port, and the input stalls while fewer than two entries are free. A byte
// can finish a held token and start one of its own, so it may yield two tokens, the last
// marked by last_of_item; tokens leave one per clock unless stalled. Offsets and lengths
// are counted in POS_BITS bits with saturation and are clamped to 16 bits on output.
// An end marker or a zero byte flushes the held token, emits EOF and restarts at offset 0.
module source_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int POS_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_source_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_item
);

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int EXTW   = POS_BITS + 16;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Lexer state
  lex_mode_t           mode_r, mode_nxt;
  logic [4:0]          pend_op_r, pend_op_nxt;
  logic [POS_BITS-1:0] open_start_r, open_start_nxt;
  logic [POS_BITS-1:0] open_len_r, open_len_nxt;
  logic [5:0]          kw_cand_r, kw_cand_nxt;
  logic [POS_BITS-1:0] byte_pos_r, byte_pos_nxt;

  // Token queue
  tok_t                q_r [QDEPTH];
  logic [QPW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]      count_r, count_nxt;

  logic                in_acc, out_acc;
  logic                eof;
  logic [7:0]          c;
  logic                flush_v, cur_v;
  tok_t                flush_tok, cur_tok;
  tok_t                slot0, slot1;
  logic [1:0]          push_n;
  logic [5:0]          word_cand;
  logic [4:0]          word_kind;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [15:0] clamp16(input logic [POS_BITS-1:0] v);
    logic [EXTW-1:0] e;
    e = EXTW'(v);
    return (e > EXTW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  // Drop keyword candidates that disagree with character ch at position idx
  function automatic logic [5:0] narrow(input logic [5:0] cand,
                                        input logic [POS_BITS-1:0] idx,
                                        input logic [7:0] ch);
    logic [5:0] r;
    r = cand;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(idx < POS_BITS'(KW_LEN[k]) && KW_TEXT[k][idx[2:0]] == ch)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [POS_BITS-1:0] start,
                                  input logic [15:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = clamp16(start);
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign c       = in_source_byte;
  assign eof     = in_end_of_input || (c == 8'h00);

  // Kind of a finished word: first candidate whose length matches
  always_comb begin
    word_kind = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (kw_cand_r[k] && open_len_r == POS_BITS'(KW_LEN[k])) begin
        word_kind = K_KEYWORD0 + 5'(k);
      end
    end
  end

  assign word_cand = narrow(kw_cand_r, open_len_r, c);

  // Lexer: next state and up to two tokens for the current byte
  always_comb begin
    mode_nxt       = mode_r;
    pend_op_nxt    = pend_op_r;
    open_start_nxt = open_start_r;
    open_len_nxt   = open_len_r;
    kw_cand_nxt    = kw_cand_r;
    byte_pos_nxt   = byte_pos_r;
    flush_v        = 1'b0;
    cur_v          = 1'b0;
    flush_tok      = '0;
    cur_tok        = '0;

    if (mode_r == LEX_COMMENT) begin
      if (eof) begin
        cur_v          = 1'b1;
        cur_tok        = mk_tok(K_EOF, byte_pos_r, 16'd0);
        mode_nxt       = LEX_IDLE;
        pend_op_nxt    = '0;
        open_start_nxt = '0;
        open_len_nxt   = '0;
        kw_cand_nxt    = '0;
        byte_pos_nxt   = '0;
      end else begin
        if (c == CH_NL) begin
          cur_v    = 1'b1;
          cur_tok  = mk_tok(K_NEWLINE, byte_pos_r, 16'd1);
          mode_nxt = LEX_IDLE;
        end
        byte_pos_nxt = sat_inc(byte_pos_r);
      end
    end else if (mode_r == LEX_OP && !eof && c == CH_EQ) begin
      // two-character operator
      cur_v        = 1'b1;
      cur_tok      = mk_tok(pend_op_r + 5'd1, open_start_r, 16'd2);
      mode_nxt     = LEX_IDLE;
      byte_pos_nxt = sat_inc(byte_pos_r);
    end else if ((mode_r == LEX_NUM && !eof && c inside {["0":"9"]}) ||
                 (mode_r == LEX_WORD && !eof && c inside {["0":"9"], ["a":"z"], ["A":"Z"]}))
    begin
      // token grows
      if (mode_r == LEX_WORD) begin
        kw_cand_nxt = word_cand;
      end
      open_len_nxt = sat_inc(open_len_r);
      byte_pos_nxt = sat_inc(byte_pos_r);
    end else begin
      // flush the held token
      case (mode_r)
        LEX_OP: begin
          flush_v   = 1'b1;
          flush_tok = mk_tok(pend_op_r, open_start_r, 16'd1);
        end
        LEX_NUM: begin
          flush_v   = 1'b1;
          flush_tok = mk_tok(K_NUM, open_start_r, clamp16(open_len_r));
        end
        LEX_WORD: begin
          flush_v   = 1'b1;
          flush_tok = mk_tok(word_kind, open_start_r, clamp16(open_len_r));
        end
        default: begin
          flush_v = 1'b0;
        end
      endcase
      mode_nxt = LEX_IDLE;

      if (eof) begin
        cur_v          = 1'b1;
        cur_tok        = mk_tok(K_EOF, byte_pos_r, 16'd0);
        pend_op_nxt    = '0;
        open_start_nxt = '0;
        open_len_nxt   = '0;
        kw_cand_nxt    = '0;
        byte_pos_nxt   = '0;
      end else begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
          mode_nxt = LEX_IDLE;
        end else if (c == CH_HASH) begin
          mode_nxt = LEX_COMMENT;
        end else if (op_kind(c) != 5'd0) begin
          mode_nxt       = LEX_OP;
          pend_op_nxt    = op_kind(c);
          open_start_nxt = byte_pos_r;
          open_len_nxt   = POS_BITS'(1);
        end else if (c inside {["0":"9"]}) begin
          mode_nxt       = LEX_NUM;
          open_start_nxt = byte_pos_r;
          open_len_nxt   = POS_BITS'(1);
        end else if (c inside {["a":"z"], ["A":"Z"]}) begin
          mode_nxt       = LEX_WORD;
          open_start_nxt = byte_pos_r;
          open_len_nxt   = POS_BITS'(1);
          kw_cand_nxt    = narrow(6'h3F, '0, c);
        end else begin
          cur_v   = 1'b1;
          cur_tok = mk_tok(single_kind(c), byte_pos_r, 16'd1);
        end
        byte_pos_nxt = sat_inc(byte_pos_r);
      end
    end

    // mark the final token of this byte
    cur_tok.last   = 1'b1;
    flush_tok.last = !cur_v;
  end

  // Pack tokens into queue slots in emission order
  always_comb begin
    slot0  = flush_v ? flush_tok : cur_tok;
    slot1  = cur_tok;
    push_n = in_acc ? (2'(flush_v) + 2'(cur_v)) : 2'd0;
  end

  assign count_nxt = count_r + QCW'(push_n) - QCW'(out_acc);

  // Lexer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= LEX_IDLE;
      pend_op_r    <= '0;
      open_start_r <= '0;
      open_len_r   <= '0;
      kw_cand_r    <= '0;
      byte_pos_r   <= '0;
    end else if (in_acc) begin
      mode_r       <= mode_nxt;
      pend_op_r    <= pend_op_nxt;
      open_start_r <= open_start_nxt;
      open_len_r   <= open_len_nxt;
      kw_cand_r    <= kw_cand_nxt;
      byte_pos_r   <= byte_pos_nxt;
    end
  end

  // Queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPW'(push_n);
      rd_ptr_r <= rd_ptr_r + QPW'(out_acc);
      count_r  <= count_nxt;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= slot0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_ptr_r + QPW'(1)] <= slot1;
    end
  end

  assign in_stall         = (count_r > QCW'(QDEPTH - 2));
  assign out_valid        = (count_r != '0);
  assign out_token_kind   = q_r[rd_ptr_r].kind;
  assign out_token_start  = q_r[rd_ptr_r].start;
  assign out_token_length = q_r[rd_ptr_r].length;
  assign out_last_of_item = q_r[rd_ptr_r].last;

  // Queue never overflows on a two-token transaction
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (QCW'(count_r) + QCW'(push_n)) <= QCW'(QDEPTH))
    else $error("token queue overflow");

  // End of input restarts the source at offset zero
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eof) |=> (byte_pos_r == '0 && mode_r == LEX_IDLE))
    else $error("end of input did not restart the lexer");

  // An open number or word always has a nonzero length
  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == LEX_NUM || mode_r == LEX_WORD) |-> open_len_r != '0)
    else $error("open token with zero length");

  // EOF tokens carry zero length and close the transaction
  a_eof_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == K_EOF) |-> (out_token_length == 16'd0 && out_last_of_item))
    else $error("malformed EOF token");

endmodule
`default_nettype wire
